// ===== rtl/register_run_word_decompressor_macros.svh =====
// Assertion macros for the decompressor RTL.
// No dependencies; included by the files that carry checks.
`ifndef REGISTER_RUN_WORD_DECOMPRESSOR_MACROS_SVH
`define REGISTER_RUN_WORD_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS
`define RRWD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("check failed");
`define RRWD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `RRWD_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`else
`define RRWD_ASSERT(lbl, clk, rstn, prop)
`define RRWD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/rrwd_pkg.sv =====
// Types and constants of the register-run word decompressor.
// No dependencies.
package rrwd_pkg;

  localparam int unsigned MAX_LANES    = 8;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned LEN_W        = 9;
  localparam int unsigned TGT_W        = 23;
  localparam int unsigned EMIT_W       = 24;
  localparam int unsigned EXT_LEN_BIAS = 31;

  localparam logic [1:0] KIND_MOVE = 2'b00;
  localparam logic [1:0] KIND_FALL = 2'b01;
  localparam logic [1:0] KIND_FLAT = 2'b10;
  localparam logic [1:0] KIND_RISE = 2'b11;
  localparam logic [3:0] EXT_LEN_CODE = 4'hF;

  typedef enum logic [3:0] {
    ST_HEADER,
    ST_OPCODE,
    ST_HIGH,
    ST_LOW,
    ST_EXTLEN,
    ST_MOVE,
    ST_RUN,
    ST_FILL,
    ST_PUSH,
    ST_MARKER
  } state_e;

  typedef enum logic {
    ALU_XOR,
    ALU_ADD
  } alu_mode_e;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
    logic             run_last;
    logic             done;
  } grp_ctl_t;

endpackage

// ===== rtl/register_run_word_decompressor.sv =====
// Register-run word decompressor: byte parser, run sequencer and register file.
// Depends on rrwd_pkg, rrwd_alu and rrwd_group_buf.
//
//   channel  signals                              direction
//   in       in_valid_i in_ready_o data_byte_i    byte stream in
//   out      out_valid_o out_ready_i word_*_o ... word groups out
//
// Header, opcode and operand bytes take one input transfer each; a move adds ST_MOVE.
// A run goes through ST_RUN, then ST_FILL and ST_PUSH per group: the shared adder makes
// one word per cycle in ST_FILL, and each group of up to GROUP_LANES words leaves from ST_PUSH.
// A push or the empty-stream marker waits while the output register is held.
// Reset clears the parser state and value registers; no input is taken during
// a move or a run.
module register_run_word_decompressor #(
  parameter int unsigned GROUP_LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [15:0] word_0_o,
  output logic [15:0] word_1_o,
  output logic [15:0] word_2_o,
  output logic [15:0] word_3_o,
  output logic [15:0] word_4_o,
  output logic [15:0] word_5_o,
  output logic [15:0] word_6_o,
  output logic [15:0] word_7_o,
  output logic [3:0]  word_count_o,
  output logic        run_last_o,
  output logic        stream_done_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  localparam int unsigned LIDX_W = $clog2(GROUP_LANES);
  localparam int unsigned WORD_W = rrwd_pkg::WORD_W;

  rrwd_pkg::state_e state_q, state_d;

  logic [WORD_W-1:0]           regs_q [4];
  logic [WORD_W-1:0]           regs_d [4];
  logic [1:0]                  hdr_cnt_q, hdr_cnt_d;
  logic [rrwd_pkg::TGT_W-1:0]  tgt_q, tgt_d;
  logic [rrwd_pkg::EMIT_W-1:0] emit_q, emit_d;
  logic [7:0]                  op_q, op_d;
  logic [7:0]                  hi_q, hi_d;
  logic [WORD_W-1:0]           opnd_q, opnd_d;
  logic [rrwd_pkg::LEN_W-1:0]  left_q, left_d;
  logic [WORD_W-1:0]           val_q, val_d;
  logic [LIDX_W-1:0]           lidx_q, lidx_d;
  logic [rrwd_pkg::CNT_W-1:0]  gcnt_q, gcnt_d;
  logic [WORD_W-1:0]           lane_q [GROUP_LANES];
  logic                        lane_we;

  logic                        in_fire;
  logic [rrwd_pkg::TGT_W-1:0]  tgt_full;
  logic [rrwd_pkg::EMIT_W-1:0] emit_sum;
  logic                        grp_done;
  logic                        fill_end;
  logic [WORD_W-1:0]           rd_val;
  logic [WORD_W-1:0]           step;
  logic [1:0]                  kind;

  rrwd_pkg::alu_mode_e alu_mode;
  logic [WORD_W-1:0]   alu_a, alu_b, alu_y;
  rrwd_pkg::grp_ctl_t  grp_ctl;
  logic                out_free;
  logic [WORD_W-1:0]   words [rrwd_pkg::MAX_LANES];

  assign in_ready_o = state_q inside {rrwd_pkg::ST_HEADER, rrwd_pkg::ST_OPCODE,
                                      rrwd_pkg::ST_HIGH, rrwd_pkg::ST_LOW,
                                      rrwd_pkg::ST_EXTLEN};
  assign in_fire  = in_valid_i && in_ready_o;
  assign tgt_full = tgt_q | (rrwd_pkg::TGT_W'(data_byte_i) << 15);
  assign emit_sum = emit_q + rrwd_pkg::EMIT_W'(gcnt_q);
  assign grp_done = emit_sum >= rrwd_pkg::EMIT_W'(tgt_q);
  assign fill_end = (left_q == rrwd_pkg::LEN_W'(1)) ||
                    (lidx_q == LIDX_W'(GROUP_LANES - 1));
  assign rd_val   = regs_q[op_q[5:4]];
  assign kind     = op_q[7:6];

  always_comb begin
    case (kind)
      rrwd_pkg::KIND_FALL: step = '1;
      rrwd_pkg::KIND_RISE: step = WORD_W'(1);
      default:             step = '0;
    endcase
  end

  assign alu_mode = (state_q == rrwd_pkg::ST_MOVE) ? rrwd_pkg::ALU_XOR : rrwd_pkg::ALU_ADD;
  assign alu_a    = (state_q == rrwd_pkg::ST_MOVE) ? rd_val : val_q;
  assign alu_b    = (state_q == rrwd_pkg::ST_MOVE) ? opnd_q : step;

  rrwd_alu u_alu (
    .mode_i (alu_mode),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .y_o    (alu_y)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrwd_pkg::ST_HEADER: begin
        if (in_fire && hdr_cnt_q == 2'd3) begin
          state_d = (tgt_full == '0) ? rrwd_pkg::ST_MARKER : rrwd_pkg::ST_OPCODE;
        end
      end
      rrwd_pkg::ST_OPCODE: begin
        if (in_fire) begin
          if (data_byte_i[7:6] == rrwd_pkg::KIND_MOVE) begin
            if (data_byte_i[1]) begin
              state_d = rrwd_pkg::ST_HIGH;
            end else if (data_byte_i[0]) begin
              state_d = rrwd_pkg::ST_LOW;
            end else begin
              state_d = rrwd_pkg::ST_MOVE;
            end
          end else if (data_byte_i[3:0] == rrwd_pkg::EXT_LEN_CODE) begin
            state_d = rrwd_pkg::ST_EXTLEN;
          end else begin
            state_d = rrwd_pkg::ST_RUN;
          end
        end
      end
      rrwd_pkg::ST_HIGH: begin
        if (in_fire) begin
          state_d = op_q[0] ? rrwd_pkg::ST_LOW : rrwd_pkg::ST_MOVE;
        end
      end
      rrwd_pkg::ST_LOW: begin
        if (in_fire) begin
          state_d = rrwd_pkg::ST_MOVE;
        end
      end
      rrwd_pkg::ST_EXTLEN: begin
        if (in_fire) begin
          state_d = rrwd_pkg::ST_RUN;
        end
      end
      rrwd_pkg::ST_MOVE: state_d = rrwd_pkg::ST_OPCODE;
      rrwd_pkg::ST_RUN:  state_d = rrwd_pkg::ST_FILL;
      rrwd_pkg::ST_FILL: begin
        if (fill_end) begin
          state_d = rrwd_pkg::ST_PUSH;
        end
      end
      rrwd_pkg::ST_PUSH: begin
        if (out_free) begin
          if (left_q != '0) begin
            state_d = rrwd_pkg::ST_FILL;
          end else begin
            state_d = grp_done ? rrwd_pkg::ST_HEADER : rrwd_pkg::ST_OPCODE;
          end
        end
      end
      rrwd_pkg::ST_MARKER: begin
        if (out_free) begin
          state_d = rrwd_pkg::ST_HEADER;
        end
      end
      default: state_d = rrwd_pkg::ST_HEADER;
    endcase
  end

  // datapath and outputs
  always_comb begin
    regs_d    = regs_q;
    hdr_cnt_d = hdr_cnt_q;
    tgt_d     = tgt_q;
    emit_d    = emit_q;
    op_d      = op_q;
    hi_d      = hi_q;
    opnd_d    = opnd_q;
    left_d    = left_q;
    val_d     = val_q;
    lidx_d    = lidx_q;
    gcnt_d    = gcnt_q;
    lane_we   = 1'b0;
    grp_ctl   = '0;
    case (state_q)
      rrwd_pkg::ST_HEADER: begin
        if (in_fire) begin
          hdr_cnt_d = hdr_cnt_q + 2'd1;
          case (hdr_cnt_q)
            2'd0:    tgt_d = '0;
            2'd1:    tgt_d = rrwd_pkg::TGT_W'(data_byte_i[7:1]);
            2'd2:    tgt_d = tgt_q | (rrwd_pkg::TGT_W'(data_byte_i) << 7);
            default: begin
              tgt_d  = tgt_full;
              emit_d = '0;
              op_d   = '0;
              hi_d   = '0;
              for (int r = 0; r < 4; r++) begin
                regs_d[r] = '0;
              end
            end
          endcase
        end
      end
      rrwd_pkg::ST_OPCODE: begin
        if (in_fire) begin
          op_d   = data_byte_i;
          hi_d   = '0;
          opnd_d = '0;
          left_d = rrwd_pkg::LEN_W'(data_byte_i[3:0]) + rrwd_pkg::LEN_W'(1);
        end
      end
      rrwd_pkg::ST_HIGH: begin
        if (in_fire) begin
          hi_d   = data_byte_i;
          opnd_d = {data_byte_i, 8'h00};
        end
      end
      rrwd_pkg::ST_LOW: begin
        if (in_fire) begin
          opnd_d = {hi_q, data_byte_i};
        end
      end
      rrwd_pkg::ST_EXTLEN: begin
        if (in_fire) begin
          left_d = rrwd_pkg::LEN_W'(data_byte_i) + rrwd_pkg::LEN_W'(rrwd_pkg::EXT_LEN_BIAS);
        end
      end
      rrwd_pkg::ST_MOVE: begin
        regs_d[op_q[3:2]] = alu_y;
      end
      rrwd_pkg::ST_RUN: begin
        val_d  = rd_val;
        lidx_d = '0;
      end
      rrwd_pkg::ST_FILL: begin
        lane_we = 1'b1;
        val_d   = alu_y;
        left_d  = left_q - rrwd_pkg::LEN_W'(1);
        lidx_d  = lidx_q + LIDX_W'(1);
        if (fill_end) begin
          gcnt_d = rrwd_pkg::CNT_W'(lidx_q) + rrwd_pkg::CNT_W'(1);
        end
      end
      rrwd_pkg::ST_PUSH: begin
        if (out_free) begin
          grp_ctl.load     = 1'b1;
          grp_ctl.count    = gcnt_q;
          grp_ctl.run_last = (left_q == '0);
          grp_ctl.done     = grp_done;
          emit_d           = emit_sum;
          lidx_d           = '0;
          if (left_q == '0 && kind != rrwd_pkg::KIND_FLAT) begin
            regs_d[op_q[5:4]] = val_q;
          end
        end
      end
      rrwd_pkg::ST_MARKER: begin
        if (out_free) begin
          grp_ctl.load = 1'b1;
          grp_ctl.done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrwd_pkg::ST_HEADER;
      hdr_cnt_q <= '0;
      tgt_q     <= '0;
      emit_q    <= '0;
      op_q      <= '0;
      hi_q      <= '0;
      for (int r = 0; r < 4; r++) begin
        regs_q[r] <= '0;
      end
    end else begin
      state_q   <= state_d;
      hdr_cnt_q <= hdr_cnt_d;
      tgt_q     <= tgt_d;
      emit_q    <= emit_d;
      op_q      <= op_d;
      hi_q      <= hi_d;
      regs_q    <= regs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    left_q <= left_d;
    val_q  <= val_d;
    lidx_q <= lidx_d;
    gcnt_q <= gcnt_d;
    if (lane_we) begin
      lane_q[lidx_q] <= val_q;
    end
  end

  rrwd_group_buf #(
    .GROUP_LANES (GROUP_LANES)
  ) u_group_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (grp_ctl),
    .lanes_i       (lane_q),
    .free_o        (out_free),
    .words_o       (words),
    .word_count_o  (word_count_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  assign word_0_o = words[0];
  assign word_1_o = words[1];
  assign word_2_o = words[2];
  assign word_3_o = words[3];
  assign word_4_o = words[4];
  assign word_5_o = words[5];
  assign word_6_o = words[6];
  assign word_7_o = words[7];

endmodule

// ===== rtl/rrwd_alu.sv =====
// Shared 16-bit unit: XOR for register moves, add for run stepping.
// Depends on rrwd_pkg.
module rrwd_alu (
  input  rrwd_pkg::alu_mode_e          mode_i,
  input  logic [rrwd_pkg::WORD_W-1:0]  a_i,
  input  logic [rrwd_pkg::WORD_W-1:0]  b_i,
  output logic [rrwd_pkg::WORD_W-1:0]  y_o
);

  always_comb begin
    case (mode_i)
      rrwd_pkg::ALU_XOR: y_o = a_i ^ b_i;
      rrwd_pkg::ALU_ADD: y_o = a_i + b_i;
      default:           y_o = a_i;
    endcase
  end

endmodule

// ===== rtl/rrwd_group_buf.sv =====
// Output register for one word group with valid/ready handshake.
// Depends on rrwd_pkg and the assertion macro header.
`include "register_run_word_decompressor_macros.svh"

module rrwd_group_buf #(
  parameter int unsigned GROUP_LANES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrwd_pkg::grp_ctl_t          ctl_i,
  input  logic [rrwd_pkg::WORD_W-1:0] lanes_i [GROUP_LANES],
  output logic                        free_o,
  output logic [rrwd_pkg::WORD_W-1:0] words_o [rrwd_pkg::MAX_LANES],
  output logic [rrwd_pkg::CNT_W-1:0]  word_count_o,
  output logic                        run_last_o,
  output logic                        stream_done_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i
);

  logic                        valid_q, valid_d;
  logic [rrwd_pkg::WORD_W-1:0] words_q [rrwd_pkg::MAX_LANES];
  logic [rrwd_pkg::CNT_W-1:0]  count_q;
  logic                        last_q;
  logic                        done_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (ctl_i.load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  for (genvar j = 0; j < rrwd_pkg::MAX_LANES; j++) begin : g_lane
    if (j < GROUP_LANES) begin : g_used
      always_ff @(posedge clk_i) begin
        if (ctl_i.load) begin
          words_q[j] <= (ctl_i.count > rrwd_pkg::CNT_W'(j)) ? lanes_i[j] : '0;
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk_i) begin
        if (ctl_i.load) begin
          words_q[j] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      count_q <= ctl_i.count;
      last_q  <= ctl_i.run_last;
      done_q  <= ctl_i.done;
    end
  end

  assign words_o       = words_q;
  assign word_count_o  = count_q;
  assign run_last_o    = last_q;
  assign stream_done_o = done_q;
  assign out_valid_o   = valid_q;

  `RRWD_ASSERT_IMP(a_load_into_free, clk_i, rst_ni, ctl_i.load, !valid_q || out_ready_i)
  `RRWD_ASSERT_IMP(a_marker_form, clk_i, rst_ni, valid_q && count_q == '0, done_q && !last_q)
  `RRWD_ASSERT_IMP(a_count_bound, clk_i, rst_ni, valid_q, count_q <= rrwd_pkg::CNT_W'(GROUP_LANES))

endmodule

// ===== tb/register_run_word_decompressor_checker.sv =====
// Checker for the register-run word decompressor: watches both channels,
// decodes every input transfer into the word groups it must produce and
// compares each output transfer against them. Depends on rrwd_pkg.
`timescale 1ns / 100ps

module register_run_word_decompressor_checker #(
  parameter int unsigned LANES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_byte_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0][15:0] words_i,
  input  logic [3:0]       word_count_i,
  input  logic             run_last_i,
  input  logic             stream_done_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  output int unsigned      mismatches_o,
  output int unsigned      outstanding_o
);

  typedef struct packed {
    logic [7:0][15:0] words;
    logic [3:0]       count;
    logic             last;
    logic             done;
  } word_group_t;

  word_group_t      groups_due[$];
  logic [15:0]      regs [4];
  logic [1:0]       header_idx;
  logic [22:0]      target_words;
  logic [23:0]      words_out;
  rrwd_pkg::state_e phase;
  logic [7:0]       held_op;
  logic [7:0]       held_high;
  int unsigned      mismatches;

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  task automatic apply_move(input logic [7:0] op, input logic [15:0] operand);
    regs[op[3:2]] = regs[op[5:4]] ^ operand;
    phase = rrwd_pkg::ST_OPCODE;
  endtask

  task automatic emit_run(input logic [7:0] op, input int unsigned len);
    logic [15:0] val;
    logic [15:0] step;
    int unsigned left;
    int unsigned cnt;
    word_group_t g;
    step = (op[7:6] == rrwd_pkg::KIND_FALL) ? 16'hFFFF :
           (op[7:6] == rrwd_pkg::KIND_RISE) ? 16'h0001 : 16'h0000;
    val = regs[op[5:4]];
    left = len;
    while (left > 0) begin
      cnt = (left < LANES) ? left : LANES;
      g = '0;
      for (int j = 0; j < cnt; j++) begin
        g.words[j] = val;
        val = val + step;
      end
      left -= cnt;
      words_out = 24'(words_out + cnt);
      g.count = 4'(cnt);
      g.last = (left == 0);
      g.done = (words_out >= target_words);
      groups_due.push_back(g);
    end
    if (op[7:6] != rrwd_pkg::KIND_FLAT) regs[op[5:4]] = val;
    phase = (words_out >= target_words) ? rrwd_pkg::ST_HEADER : rrwd_pkg::ST_OPCODE;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    word_group_t marker;
    case (phase)
      rrwd_pkg::ST_OPCODE: begin
        if (b[7:6] == rrwd_pkg::KIND_MOVE) begin
          if (b[1]) begin
            held_op = b;
            phase = rrwd_pkg::ST_HIGH;
          end else if (b[0]) begin
            held_op = b;
            held_high = '0;
            phase = rrwd_pkg::ST_LOW;
          end else begin
            apply_move(b, 16'h0000);
          end
        end else if (b[3:0] == rrwd_pkg::EXT_LEN_CODE) begin
          held_op = b;
          phase = rrwd_pkg::ST_EXTLEN;
        end else begin
          emit_run(b, b[3:0] + 1);
        end
      end
      rrwd_pkg::ST_HIGH: begin
        held_high = b;
        if (held_op[0]) phase = rrwd_pkg::ST_LOW;
        else apply_move(held_op, {b, 8'h00});
      end
      rrwd_pkg::ST_LOW: apply_move(held_op, {held_high, b});
      rrwd_pkg::ST_EXTLEN: emit_run(held_op, b + rrwd_pkg::EXT_LEN_BIAS);
      default: begin
        // header: byte 0 ignored, size bit 0 dropped
        case (header_idx)
          2'd0: target_words = '0;
          2'd1: target_words = 23'(b >> 1);
          2'd2: target_words |= 23'(b) << 7;
          default: target_words |= 23'(b) << 15;
        endcase
        if (header_idx != 2'd3) begin
          header_idx++;
        end else begin
          header_idx = '0;
          for (int i = 0; i < 4; i++) regs[i] = '0;
          words_out = '0;
          held_op = '0;
          held_high = '0;
          if (target_words == '0) begin
            marker = '0;
            marker.done = 1'b1;
            groups_due.push_back(marker);
            phase = rrwd_pkg::ST_HEADER;
          end else begin
            phase = rrwd_pkg::ST_OPCODE;
          end
        end
      end
    endcase
  endtask

  task automatic compare_group();
    word_group_t want;
    if (groups_due.size() == 0) begin
      mismatches++;
      $display("%0t ns: group with none expected, expected nothing, got count %0d",
               $time, word_count_i);
    end else begin
      want = groups_due.pop_front();
      for (int j = 0; j < 8; j++)
        check_field($sformatf("word_%0d", j), want.words[j], words_i[j]);
      check_field("word_count", 16'(want.count), 16'(word_count_i));
      check_field("run_last", 16'(want.last), 16'(run_last_i));
      check_field("stream_done", 16'(want.done), 16'(stream_done_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_due.delete();
      for (int i = 0; i < 4; i++) regs[i] = '0;
      header_idx = '0;
      target_words = '0;
      words_out = '0;
      phase = rrwd_pkg::ST_HEADER;
      held_op = '0;
      held_high = '0;
      mismatches = 0;
      mismatches_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i);
      if (out_valid_i && out_ready_i) compare_group();
      mismatches_o <= mismatches;
      outstanding_o <= groups_due.size();
    end
  end

endmodule

// ===== tb/tb_register_run_word_decompressor.sv =====
// Top of the decompressor testbench: clock, reset, byte-stream stimulus,
// output back-pressure and the verdict. Depends on rrwd_pkg, the RTL and
// register_run_word_decompressor_checker.
`timescale 1ns / 100ps

module tb_register_run_word_decompressor;

  localparam int unsigned GROUP_LANES  = 8;
  localparam int unsigned RANDOM_ITEMS = 110;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  data_byte_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] word_0_o, word_1_o, word_2_o, word_3_o;
  logic [15:0] word_4_o, word_5_o, word_6_o, word_7_o;
  logic [3:0]  word_count_o;
  logic        run_last_o;
  logic        stream_done_o;
  logic        out_valid_o;
  logic        out_ready_i;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b0;
  bit          held = 1'b0;

  register_run_word_decompressor #(
    .GROUP_LANES(GROUP_LANES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .word_0_o      (word_0_o),
    .word_1_o      (word_1_o),
    .word_2_o      (word_2_o),
    .word_3_o      (word_3_o),
    .word_4_o      (word_4_o),
    .word_5_o      (word_5_o),
    .word_6_o      (word_6_o),
    .word_7_o      (word_7_o),
    .word_count_o  (word_count_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  register_run_word_decompressor_checker #(
    .LANES(GROUP_LANES)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .words_i       ({word_7_o, word_6_o, word_5_o, word_4_o,
                     word_3_o, word_2_o, word_1_o, word_0_o}),
    .word_count_i  (word_count_o),
    .run_last_i    (run_last_o),
    .stream_done_i (stream_done_o),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one byte transfer; valid stays high across back-to-back bytes of a burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // random opcode with its operands; returns the words the run adds
  task automatic send_op(output int unsigned words);
    logic [7:0] op;
    logic [7:0] ext;
    op = 8'($urandom_range(0, 255));
    send_byte(op);
    words = 0;
    if (op[7:6] == rrwd_pkg::KIND_MOVE) begin
      if (op[1]) send_byte(8'($urandom_range(0, 255)));
      if (op[0]) send_byte(8'($urandom_range(0, 255)));
    end else if (op[3:0] == rrwd_pkg::EXT_LEN_CODE) begin
      ext = 8'($urandom_range(0, 255));
      send_byte(ext);
      words = ext + rrwd_pkg::EXT_LEN_BIAS;
    end else begin
      words = op[3:0] + 1;
    end
  endtask

  task automatic send_stream(input int unsigned target, input bit odd);
    logic [23:0] size;
    int unsigned w;
    int remaining;
    size = 24'(target * 2 + odd);
    gaps_on = ($urandom_range(0, 3) != 0);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(size[7:0]);
    send_byte(size[15:8]);
    send_byte(size[23:16]);
    remaining = target;
    while (remaining > 0) begin
      send_op(w);
      remaining -= int'(w);
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    int unsigned pick;
    int unsigned w;
    directed = '{
      8'hFF, 8'h01, 8'h00, 8'h00,               // size 1 byte: empty stream
      8'hAB, 8'h08, 8'h00, 8'h00,               // 4 words
      8'h07, 8'hFF, 8'hFF,                      // r1 = r0 ^ FFFF
      8'hD2,                                    // rising r1, wraps
      8'h40,                                    // falling r0, reaches size
      8'h00, 8'h02, 8'h00, 8'h00,               // 1 word
      8'h1A, 8'h80,                             // r2 = r1 ^ 8000
      8'h2D, 8'h5A,                             // r3 = r2 ^ 005A
      8'h30,                                    // r0 = r3
      8'h8F, 8'hFF                              // flat 286 words, overrun
    };
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    data_byte_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);

    while (bytes_sent < directed.size() + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_stream(0, 1'($urandom_range(0, 1)));
      else if (pick == 9) send_stream($urandom_range(100, 400), 1'($urandom_range(0, 1)));
      else send_stream($urandom_range(1, 48), 1'($urandom_range(0, 1)));
    end

    // largest size; left unfinished
    gaps_on = 1'b1;
    repeat (4) send_byte(8'hFF);
    repeat (8) send_op(w);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // output stalls in segments of random style, plus one long hold-off
  initial begin
    int unsigned seg;
    int unsigned style;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      seg = $urandom_range(5, 60);
      style = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk_i);
        if (!held && bytes_sent >= 60) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 4) != 0);
          default: out_ready_i <= !out_ready_i;
        endcase
      end
    end
  end

endmodule
